[src/rgb565_pixel_compositor_core_macros.svh]
`ifndef RGB565_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define RGB565_PIXEL_COMPOSITOR_CORE_MACROS_SVH

// check a condition at every rising clock edge outside reset
`define RPC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// check a consequence in the same cycle
`define RPC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the next cycle
`define RPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rpc_pkg.sv]
package rpc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [2:0] CFG_BLEND_MODE   = 3'd0;
    localparam logic [2:0] CFG_KEY_ENABLE   = 3'd1;
    localparam logic [2:0] CFG_TINT_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_SRC_ARGB4444 = 3'd3;
    localparam logic [2:0] CFG_COLOR_KEY    = 3'd4;
    localparam logic [2:0] CFG_CONST_ALPHA  = 3'd5;
    localparam logic [2:0] CFG_TINT_RGB     = 3'd6;

    localparam logic [2:0] MODE_COPY  = 3'd0;
    localparam logic [2:0] MODE_KEY   = 3'd1;
    localparam logic [2:0] MODE_CONST = 3'd2;
    localparam logic [2:0] MODE_ALPHA = 3'd3;
    localparam logic [2:0] MODE_ADD   = 3'd4;
    localparam logic [2:0] MODE_MUL   = 3'd5;

    localparam logic [7:0]  CONST_ALPHA_RST = 8'hFF;
    localparam logic [23:0] TINT_RGB_RST    = 24'hFFFFFF;

    typedef enum logic [2:0] {
        PATH_SKIP,
        PATH_COPY,
        PATH_MIX,
        PATH_ADD,
        PATH_MUL
    } rpc_path_t;

    typedef struct packed {
        rpc_path_t   path;
        logic [7:0]  alpha;
        logic [4:0]  src_r;
        logic [5:0]  src_g;
        logic [4:0]  src_b;
        logic [15:0] dst;
    } rpc_item_t;

    // round(t / (2^k - 1)) without a divider
    function automatic logic [16:0] rdiv(input logic [16:0] t, input int unsigned k);
        logic [16:0] m;
        m = t + (17'd1 << (k - 1));
        return (m + (m >> k)) >> k;
    endfunction

endpackage

[src/rpc_front.sv]
module rpc_front
    import rpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    input  logic [15:0]            s_src_pixel,
    input  logic [15:0]            s_dst_pixel,
    output logic                   push_valid,
    output rpc_item_t              push_item
);

    logic [2:0]  blend_mode_reg;
    logic        key_enable_reg;
    logic        tint_enable_reg;
    logic        src_argb_reg;
    logic [15:0] color_key_reg;
    logic [7:0]  const_alpha_reg;
    logic [23:0] tint_rgb_reg;

    logic        argb_path;
    logic        key_hit;
    logic [3:0]  a4;
    logic [4:0]  raw_r;
    logic [5:0]  raw_g;
    logic [4:0]  raw_b;
    logic [13:0] tp_r;
    logic [13:0] tp_g;
    logic [13:0] tp_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_mode_reg  <= MODE_COPY;
            key_enable_reg  <= 1'b0;
            tint_enable_reg <= 1'b0;
            src_argb_reg    <= 1'b0;
            color_key_reg   <= '0;
            const_alpha_reg <= CONST_ALPHA_RST;
            tint_rgb_reg    <= TINT_RGB_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BLEND_MODE:   blend_mode_reg  <= cfg_data[2:0];
                CFG_KEY_ENABLE:   key_enable_reg  <= cfg_data[0];
                CFG_TINT_ENABLE:  tint_enable_reg <= cfg_data[0];
                CFG_SRC_ARGB4444: src_argb_reg    <= cfg_data[0];
                CFG_COLOR_KEY:    color_key_reg   <= cfg_data[15:0];
                CFG_CONST_ALPHA:  const_alpha_reg <= cfg_data[7:0];
                CFG_TINT_RGB:     tint_rgb_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        argb_path = (blend_mode_reg == MODE_ALPHA) && src_argb_reg;
        key_hit   = ((blend_mode_reg == MODE_KEY) || key_enable_reg) &&
                    (s_src_pixel == color_key_reg);
        a4        = s_src_pixel[15:12];

        if (argb_path) begin
            raw_r = {s_src_pixel[11:8], s_src_pixel[11]};
            raw_g = {s_src_pixel[7:4], s_src_pixel[7:6]};
            raw_b = {s_src_pixel[3:0], s_src_pixel[3]};
        end else begin
            raw_r = s_src_pixel[15:11];
            raw_g = s_src_pixel[10:5];
            raw_b = s_src_pixel[4:0];
        end

        tp_r = 14'(raw_r) * 14'(tint_rgb_reg[23:16]);
        tp_g = 14'(raw_g) * 14'(tint_rgb_reg[15:8]);
        tp_b = 14'(raw_b) * 14'(tint_rgb_reg[7:0]);

        push_item.dst = s_dst_pixel;
        if (tint_enable_reg) begin
            push_item.src_r = 5'(rdiv(17'(tp_r), 8));
            push_item.src_g = 6'(rdiv(17'(tp_g), 8));
            push_item.src_b = 5'(rdiv(17'(tp_b), 8));
        end else begin
            push_item.src_r = raw_r;
            push_item.src_g = raw_g;
            push_item.src_b = raw_b;
        end

        if (argb_path) begin
            push_item.alpha = {a4, a4};
            push_item.path  = (a4 == 4'd0) ? PATH_SKIP : PATH_MIX;
        end else begin
            push_item.alpha = const_alpha_reg;
            if (key_hit) begin
                push_item.path = PATH_SKIP;
            end else begin
                case (blend_mode_reg)
                    MODE_CONST: push_item.path = PATH_MIX;
                    MODE_ADD:   push_item.path = PATH_ADD;
                    MODE_MUL:   push_item.path = PATH_MUL;
                    default:    push_item.path = PATH_COPY;
                endcase
            end
        end
    end

    assign push_valid = s_valid;

endmodule

[src/rpc_queue.sv]
`include "rgb565_pixel_compositor_core_macros.svh"

module rpc_queue
    import rpc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  rpc_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rpc_item_t pop_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rpc_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `RPC_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `RPC_ASSERT_IMPLY(a_empty_ptrs, aclk, aresetn, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with unequal pointers")
    `RPC_ASSERT_NEXT(a_push_count, aclk, aresetn, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "push did not raise count")

endmodule

[src/rpc_back.sv]
`include "rgb565_pixel_compositor_core_macros.svh"

module rpc_back
    import rpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  rpc_item_t   pop_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_pixel,
    output logic        m_write_enable
);

    typedef struct packed {
        rpc_path_t   path;
        logic [4:0]  src_r;
        logic [5:0]  src_g;
        logic [4:0]  src_b;
        logic [4:0]  dst_r;
        logic [5:0]  dst_g;
        logic [4:0]  dst_b;
        logic [13:0] pa_r;
        logic [13:0] pa_g;
        logic [13:0] pa_b;
        logic [13:0] pb_r;
        logic [13:0] pb_g;
        logic [13:0] pb_b;
    } rpc_prod_t;

    logic        b1_valid_reg;
    logic        b1_valid_next;
    rpc_prod_t   b1_reg;
    rpc_prod_t   b1_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_pixel_reg;
    logic [15:0] m_pixel_next;
    logic        m_we_reg;
    logic        m_we_next;
    logic        b1_ready;
    logic        b2_ready;
    logic [7:0]  wa_r;
    logic [7:0]  wa_g;
    logic [7:0]  wa_b;
    logic [7:0]  inv_alpha;
    logic [5:0]  sum_r;
    logic [6:0]  sum_g;
    logic [5:0]  sum_b;
    logic [4:0]  res_r;
    logic [5:0]  res_g;
    logic [4:0]  res_b;

    assign b2_ready  = !m_valid_reg || m_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign pop_ready = b1_ready;

    always_comb begin
        b1_next.path  = pop_item.path;
        b1_next.src_r = pop_item.src_r;
        b1_next.src_g = pop_item.src_g;
        b1_next.src_b = pop_item.src_b;
        b1_next.dst_r = pop_item.dst[15:11];
        b1_next.dst_g = pop_item.dst[10:5];
        b1_next.dst_b = pop_item.dst[4:0];

        if (pop_item.path == PATH_MUL) begin
            wa_r = 8'(pop_item.dst[15:11]);
            wa_g = 8'(pop_item.dst[10:5]);
            wa_b = 8'(pop_item.dst[4:0]);
        end else begin
            wa_r = pop_item.alpha;
            wa_g = pop_item.alpha;
            wa_b = pop_item.alpha;
        end
        inv_alpha = 8'd255 - pop_item.alpha;

        b1_next.pa_r = 14'(pop_item.src_r) * 14'(wa_r);
        b1_next.pa_g = 14'(pop_item.src_g) * 14'(wa_g);
        b1_next.pa_b = 14'(pop_item.src_b) * 14'(wa_b);
        b1_next.pb_r = 14'(pop_item.dst[15:11]) * 14'(inv_alpha);
        b1_next.pb_g = 14'(pop_item.dst[10:5]) * 14'(inv_alpha);
        b1_next.pb_b = 14'(pop_item.dst[4:0]) * 14'(inv_alpha);

        b1_valid_next = b1_ready ? pop_valid : b1_valid_reg;
    end

    always_comb begin
        sum_r = 6'(b1_reg.src_r) + 6'(b1_reg.dst_r);
        sum_g = 7'(b1_reg.src_g) + 7'(b1_reg.dst_g);
        sum_b = 6'(b1_reg.src_b) + 6'(b1_reg.dst_b);
        m_we_next = 1'b1;
        case (b1_reg.path)
            PATH_MIX: begin
                res_r = 5'(rdiv(17'(b1_reg.pa_r) + 17'(b1_reg.pb_r), 8));
                res_g = 6'(rdiv(17'(b1_reg.pa_g) + 17'(b1_reg.pb_g), 8));
                res_b = 5'(rdiv(17'(b1_reg.pa_b) + 17'(b1_reg.pb_b), 8));
            end
            PATH_MUL: begin
                res_r = 5'(rdiv(17'(b1_reg.pa_r), 5));
                res_g = 6'(rdiv(17'(b1_reg.pa_g), 6));
                res_b = 5'(rdiv(17'(b1_reg.pa_b), 5));
            end
            PATH_ADD: begin
                res_r = sum_r[5] ? 5'h1F : sum_r[4:0];
                res_g = sum_g[6] ? 6'h3F : sum_g[5:0];
                res_b = sum_b[5] ? 5'h1F : sum_b[4:0];
            end
            PATH_COPY: begin
                res_r = b1_reg.src_r;
                res_g = b1_reg.src_g;
                res_b = b1_reg.src_b;
            end
            default: begin
                res_r     = '0;
                res_g     = '0;
                res_b     = '0;
                m_we_next = 1'b0;
            end
        endcase
        m_pixel_next = {res_r, res_g, res_b};
        m_valid_next = b2_ready ? b1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            b1_valid_reg <= b1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_ready && pop_valid) begin
            b1_reg <= b1_next;
        end
        if (b2_ready && b1_valid_reg) begin
            m_pixel_reg <= m_pixel_next;
            m_we_reg    <= m_we_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_pixel    = m_pixel_reg;
    assign m_write_enable = m_we_reg;

    `RPC_ASSERT_IMPLY(a_skip_zero, aclk, aresetn, m_valid_reg && !m_we_reg, m_pixel_reg == '0, "skipped write carries nonzero pixel")
    `RPC_ASSERT_NEXT(a_b1_hold, aclk, aresetn, b1_valid_reg && !b2_ready, b1_valid_reg && $stable(b1_reg), "product stage lost data under stall")
    `RPC_ASSERT_NEXT(a_b1_load, aclk, aresetn, pop_valid && pop_ready, b1_valid_reg, "popped item not captured")

endmodule

[src/rgb565_pixel_compositor_core.sv]
// channel   ports                                        direction
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data     in
// source    s_valid/s_ready, s_src_pixel, s_dst_pixel    in
// result    m_valid/m_ready, m_out_pixel, m_write_enable out
//
// One pixel per clock sustained while m_ready stays high; a result passes, after its source is accepted,
// through the queue entry, the product register and the output register.
// The back end is the per-channel multiply stage followed by the rounding/pack stage.
// aresetn (synchronous) restores register defaults and empties queue and pipeline.
// m_ready low fills the back stages and then the queue; s_ready drops when the queue is full.
// Configuration writes are taken every cycle.
module rgb565_pixel_compositor_core
    import rpc_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [15:0]            s_src_pixel,
    input  logic [15:0]            s_dst_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_out_pixel,
    output logic                   m_write_enable
);

    logic      push_valid;
    logic      push_ready;
    rpc_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    rpc_item_t pop_item;

    assign s_ready = push_ready;

    rpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_src_pixel (s_src_pixel),
        .s_dst_pixel (s_dst_pixel),
        .push_valid  (push_valid),
        .push_item   (push_item)
    );

    rpc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rpc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_write_enable (m_write_enable)
    );

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpc_pkg::*;

    localparam logic [2:0] CFG_UNUSED   = 3'd7;
    localparam logic [2:0] MODE_SPARE6  = 3'd6;
    localparam logic [2:0] MODE_SPARE7  = 3'd7;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_PHASES  = 24;
    localparam int unsigned PHASE_PIXELS   = 56;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
    } pixel_pair_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        we;
    } pixel_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [15:0]            s_src_pixel = '0;
    logic [15:0]            s_dst_pixel = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [15:0]            m_out_pixel;
    logic                   m_write_enable;

    logic [2:0]  mode_q     = MODE_COPY;
    logic        key_en_q   = 1'b0;
    logic        tint_en_q  = 1'b0;
    logic        argb_q     = 1'b0;
    logic [15:0] key_q      = '0;
    logic [7:0]  alpha_q    = CONST_ALPHA_RST;
    logic [23:0] tint_q     = TINT_RGB_RST;

    pixel_pair_t   pending_pairs[$];
    pixel_result_t expected_pixels[$];

    logic        src_fire = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned skipped_writes = 0;
    int unsigned settings_count = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    rgb565_pixel_compositor_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_pixel    (s_src_pixel),
        .s_dst_pixel    (s_dst_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_write_enable (m_write_enable)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned round_div(input int unsigned t, input int unsigned k);
        int unsigned m;
        m = t + (1 << (k - 1));
        return (m + (m >> k)) >> k;
    endfunction

    function automatic int unsigned mix_channel(input int unsigned s, input int unsigned d,
                                                input int unsigned a);
        return round_div(s * a + d * (255 - a), 8);
    endfunction

    function automatic logic [15:0] pack_rgb(input int unsigned r, input int unsigned g,
                                             input int unsigned b);
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    function automatic pixel_result_t compose_pixel(input logic [15:0] src,
                                                    input logic [15:0] dst);
        int unsigned tint_r, tint_g, tint_b;
        int unsigned dr, dg, db, sr, sg, sb, a8, r, g, b;
        pixel_result_t res;
        tint_r = 32'(tint_q[23:16]);
        tint_g = 32'(tint_q[15:8]);
        tint_b = 32'(tint_q[7:0]);
        dr = 32'(dst[15:11]);
        dg = 32'(dst[10:5]);
        db = 32'(dst[4:0]);
        res = '0;
        res.we = 1'b1;
        if (mode_q == MODE_ALPHA && argb_q) begin
            a8 = 32'({src[15:12], src[15:12]});
            sr = 32'({src[11:8], src[11]});
            sg = 32'({src[7:4], src[7:6]});
            sb = 32'({src[3:0], src[3]});
            if (a8 == 0) begin
                res.we = 1'b0;
            end else begin
                if (tint_en_q) begin
                    sr = round_div(sr * tint_r, 8);
                    sg = round_div(sg * tint_g, 8);
                    sb = round_div(sb * tint_b, 8);
                end
                res.pixel = pack_rgb(mix_channel(sr, dr, a8), mix_channel(sg, dg, a8),
                                     mix_channel(sb, db, a8));
            end
        end else begin
            sr = 32'(src[15:11]);
            sg = 32'(src[10:5]);
            sb = 32'(src[4:0]);
            if (tint_en_q) begin
                sr = round_div(sr * tint_r, 8);
                sg = round_div(sg * tint_g, 8);
                sb = round_div(sb * tint_b, 8);
            end
            if ((mode_q == MODE_KEY || key_en_q) && src == key_q) begin
                res.we = 1'b0;
            end else begin
                case (mode_q)
                    MODE_CONST: begin
                        res.pixel = pack_rgb(mix_channel(sr, dr, 32'(alpha_q)),
                                             mix_channel(sg, dg, 32'(alpha_q)),
                                             mix_channel(sb, db, 32'(alpha_q)));
                    end
                    MODE_ADD: begin
                        r = sr + dr;
                        g = sg + dg;
                        b = sb + db;
                        if (r > 31) r = 31;
                        if (g > 63) g = 63;
                        if (b > 31) b = 31;
                        res.pixel = pack_rgb(r, g, b);
                    end
                    MODE_MUL: begin
                        res.pixel = pack_rgb(round_div(sr * dr, 5), round_div(sg * dg, 6),
                                             round_div(sb * db, 5));
                    end
                    default: begin
                        res.pixel = pack_rgb(sr, sg, sb);
                    end
                endcase
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    always @(negedge aclk) begin
        pixel_pair_t pair;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || src_fire) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                pair = pending_pairs.pop_front();
                s_valid <= 1'b1;
                s_src_pixel <= pair.src;
                s_dst_pixel <= pair.dst;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        pixel_result_t want;
        src_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction pixel %h we %b",
                                              m_out_pixel, m_write_enable));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_out_pixel !== want.pixel)
                        report_mismatch($sformatf("out_pixel %h, want %h",
                                                  m_out_pixel, want.pixel));
                    if (m_write_enable !== want.we)
                        report_mismatch($sformatf("write_enable %b, want %b",
                                                  m_write_enable, want.we));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                want = compose_pixel(s_src_pixel, s_dst_pixel);
                if (!want.we) skipped_writes++;
                expected_pixels.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d transactions outstanding",
                     expected_pixels.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BLEND_MODE:   mode_q = val[2:0];
            CFG_KEY_ENABLE:   key_en_q = val[0];
            CFG_TINT_ENABLE:  tint_en_q = val[0];
            CFG_SRC_ARGB4444: argb_q = val[0];
            CFG_COLOR_KEY:    key_q = val[15:0];
            CFG_CONST_ALPHA:  alpha_q = val[7:0];
            CFG_TINT_RGB:     tint_q = val[23:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_settings(input logic [2:0] mode, input logic key_en,
                                    input logic tint_en, input logic argb,
                                    input logic [15:0] key, input logic [7:0] alpha,
                                    input logic [23:0] tint);
        write_reg(CFG_BLEND_MODE, 24'(mode));
        write_reg(CFG_KEY_ENABLE, 24'(key_en));
        write_reg(CFG_TINT_ENABLE, 24'(tint_en));
        write_reg(CFG_SRC_ARGB4444, 24'(argb));
        write_reg(CFG_COLOR_KEY, 24'(key));
        write_reg(CFG_CONST_ALPHA, 24'(alpha));
        write_reg(CFG_TINT_RGB, tint);
        settings_count++;
    endtask

    task automatic queue_pair(input logic [15:0] src, input logic [15:0] dst);
        pending_pairs.push_back('{src: src, dst: dst});
        items_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (results_seen != items_queued);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_traffic(input int unsigned profile);
        case (profile % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
        endcase
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_settings(input int unsigned phase);
        logic [2:0]  mode;
        logic        argb;
        logic [15:0] key;
        logic [7:0]  alpha;
        logic [23:0] tint;
        if (phase < 8)
            mode = 3'(phase);
        else if ($urandom_range(9) < 8)
            mode = 3'($urandom_range(5));
        else
            mode = 3'($urandom_range(7, 6));
        argb = (mode == MODE_ALPHA) ? ($urandom_range(3) != 0) : 1'($urandom_range(1));
        case (phase)
            0: begin key = 16'h0000; alpha = 8'h00; tint = 24'h000000; end
            1: begin key = 16'hFFFF; alpha = 8'hFF; tint = 24'hFFFFFF; end
            default: begin
                key = 16'($urandom_range(16'hFFFF));
                alpha = pick_byte();
                tint = {pick_byte(), pick_byte(), pick_byte()};
            end
        endcase
        program_settings(mode, 1'($urandom_range(1)), 1'($urandom_range(1)), argb, key,
                         alpha, tint);
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, 24'($urandom_range(24'hFFFFFF)));
    endtask

    task automatic queue_random_pairs(input int unsigned count);
        logic [15:0] src;
        logic [15:0] dst;
        repeat (count) begin
            src = 16'($urandom_range(16'hFFFF));
            dst = 16'($urandom_range(16'hFFFF));
            case ($urandom_range(15))
                0, 1: src = key_q;
                2: src = 16'h0000;
                3: src = 16'hFFFF;
                4: dst = 16'h0000;
                5: dst = 16'hFFFF;
                default: ;
            endcase
            queue_pair(src, dst);
        end
    endtask

    initial begin
        int unsigned phase;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        set_traffic(0);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'hA5A5, 16'h5A5A);
        wait_drained();
        write_reg(CFG_UNUSED, 24'hFFFFFF);

        set_traffic(1);
        program_settings(MODE_KEY, 1'b0, 1'b0, 1'b0, 16'hF81F, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hF81F, 16'h1234);
        queue_pair(16'hF81E, 16'h1234);
        wait_drained();

        set_traffic(2);
        program_settings(MODE_ADD, 1'b1, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h8410, 16'h8410);
        queue_pair(16'hF7DF, 16'hFFFF);
        wait_drained();

        set_traffic(3);
        program_settings(MODE_CONST, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h80, 24'hFFFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'hFFFF);
        wait_drained();

        set_traffic(0);
        program_settings(MODE_ALPHA, 1'b1, 1'b0, 1'b1, 16'h8421, 8'hFF, 24'hFFFFFF);
        queue_pair(16'h0FFF, 16'h0000);
        queue_pair(16'h8421, 16'hFFFF);
        queue_pair(16'hF00F, 16'h0000);
        wait_drained();

        program_settings(MODE_ALPHA, 1'b0, 1'b0, 1'b0, 16'h0000, 8'hFF, 24'hFFFFFF);
        queue_pair(16'h1234, 16'hABCD);
        wait_drained();

        set_traffic(2);
        program_settings(MODE_MUL, 1'b0, 1'b0, 1'b0, 16'h0000, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h1234);
        queue_pair(16'h0842, 16'h7BEF);
        wait_drained();

        program_settings(MODE_SPARE6, 1'b0, 1'b0, 1'b0, 16'h0000, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hABCD, 16'h0000);
        wait_drained();

        program_settings(MODE_SPARE7, 1'b0, 1'b0, 1'b1, 16'h0000, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hABCD, 16'h0000);
        wait_drained();

        program_settings(MODE_CONST, 1'b0, 1'b0, 1'b1, 16'h0000, 8'hFF, 24'hFFFFFF);
        queue_pair(16'hF0F0, 16'h0F0F);
        wait_drained();

        program_settings(MODE_COPY, 1'b0, 1'b1, 1'b0, 16'h0000, 8'hFF, 24'h000000);
        queue_pair(16'hFFFF, 16'h0000);
        wait_drained();

        program_settings(MODE_ALPHA, 1'b0, 1'b1, 1'b1, 16'h0000, 8'hFF, 24'h80FF40);
        queue_pair(16'hFFFF, 16'h0000);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_traffic(phase);
            random_settings(phase);
            if (phase == 5) begin
                queue_random_pairs(PHASE_PIXELS / 2);
                wait_drained();
                queue_random_pairs(PHASE_PIXELS - PHASE_PIXELS / 2);
            end else begin
                queue_random_pairs(PHASE_PIXELS);
            end
            wait_drained();
        end

        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d transactions never arrived", expected_pixels.size()));
        $display("covered %0d pixels under %0d register settings, %0d with the write skipped",
                 items_queued, settings_count, skipped_writes);
        $display("all blend modes incl. spare codes, keying, tint and per-pixel alpha exercised");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[rgb565_pixel_compositor_core.f]
+incdir+src
src/rpc_pkg.sv
src/rpc_front.sv
src/rpc_queue.sv
src/rpc_back.sv
src/rgb565_pixel_compositor_core.sv
bench/tb.sv
